// ===== hdl/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and constants of the LRU page replacement block
// Holds the frame count, the width rules and the records that travel along
// the cell chain and from the controller to every cell.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 16;

  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int AGE_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int K_W    = $clog2(FRAMES + 1);
  localparam int PFLD_W = 16;
  localparam int FIDX_W = 4;
  localparam int CNT_W  = 16;
  localparam int CFG_W  = 5;

  localparam logic [AGE_W-1:0] AGE_MAX   = AGE_W'(FRAMES - 1);
  localparam logic [CNT_W-1:0] FAULT_MAX = '1;

  // search record handed from cell to cell
  typedef struct packed {
    logic                 tok;
    logic                 hit_found;
    logic [IDX_W-1:0]     hit_idx;
    logic [AGE_W-1:0]     hit_age;
    logic                 empty_found;
    logic [IDX_W-1:0]     empty_idx;
    logic [IDX_W-1:0]     best_idx;
    logic [AGE_W-1:0]     best_age;
    logic [PAGE_BITS-1:0] best_page;
  } carry_t;

  // update broadcast to all cells when a transaction commits
  typedef struct packed {
    logic                 en;
    logic                 is_hit;
    logic [AGE_W-1:0]     hit_age;
    logic [IDX_W-1:0]     frame;
    logic [PAGE_BITS-1:0] page;
    logic                 clear;
  } cmd_t;

  function automatic logic [PAGE_BITS-1:0] page_from_field(logic [PFLD_W-1:0] v);
    logic [PAGE_BITS+PFLD_W-1:0] w;
    w = {{PAGE_BITS{1'b0}}, v};
    return w[PAGE_BITS-1:0];
  endfunction

  function automatic logic [PFLD_W-1:0] page_to_field(logic [PAGE_BITS-1:0] p);
    logic [PAGE_BITS+PFLD_W-1:0] w;
    w = {{PFLD_W{1'b0}}, p};
    return w[PFLD_W-1:0];
  endfunction

  function automatic logic [FIDX_W-1:0] idx_to_field(logic [IDX_W-1:0] f);
    logic [IDX_W+FIDX_W-1:0] w;
    w = {{FIDX_W{1'b0}}, f};
    return w[FIDX_W-1:0];
  endfunction

endpackage

// ===== hdl/lpr_cell.sv =====
// ----------------------------------------------------------------------------
// lpr_cell: one page frame of the LRU chain
// Holds page, valid bit and age rank of one frame, folds itself into the
// search record passing by, and applies the commit broadcast.
// ----------------------------------------------------------------------------
module lpr_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lpr_pkg::IDX_W-1:0]     idx_i,
  input  logic                          active_i,
  input  logic [lpr_pkg::PAGE_BITS-1:0] page_i,
  input  lpr_pkg::carry_t               carry_i,
  output lpr_pkg::carry_t               carry_o,
  input  lpr_pkg::cmd_t                 cmd_i
);

  logic [lpr_pkg::PAGE_BITS-1:0] page_q;
  logic                          valid_q, valid_d;
  logic [lpr_pkg::AGE_W-1:0]     age_q, age_d;
  lpr_pkg::carry_t               carry_q, carry_d;
  logic                          is_target;

  assign is_target = (cmd_i.frame == idx_i);

  always_comb begin
    carry_d = carry_i;
    if (carry_i.tok && active_i) begin
      if (valid_q && (page_q == page_i) && !carry_i.hit_found) begin
        carry_d.hit_found = 1'b1;
        carry_d.hit_idx   = idx_i;
        carry_d.hit_age   = age_q;
      end
      if (!valid_q && !carry_i.empty_found) begin
        carry_d.empty_found = 1'b1;
        carry_d.empty_idx   = idx_i;
      end
      // first active frame seeds the victim, later ones replace only if older
      if ((idx_i == '0) || (age_q > carry_i.best_age)) begin
        carry_d.best_idx  = idx_i;
        carry_d.best_age  = age_q;
        carry_d.best_page = page_q;
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    age_d   = age_q;
    if (cmd_i.en) begin
      if (is_target) begin
        age_d = '0;
        if (!cmd_i.is_hit) begin
          valid_d = 1'b1;
        end
      end else if (valid_q && (age_q != lpr_pkg::AGE_MAX) &&
                   (!cmd_i.is_hit || (age_q < cmd_i.hit_age))) begin
        age_d = age_q + 1'b1;
      end
      if (cmd_i.clear) begin
        valid_d = 1'b0;
        age_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
      carry_q <= '0;
    end else begin
      valid_q <= valid_d;
      age_q   <= age_d;
      carry_q <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.en && is_target && !cmd_i.is_hit) begin
      page_q <= cmd_i.page;
    end
  end

  assign carry_o = carry_q;

endmodule

// ===== hdl/lru_page_replacement_top.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement_top: fully associative LRU page frame manager
// One reference is handled at a time. Its search record walks the cell chain
//   one frame per cycle, the finished record is latched, and the update
//   commits once the result register is free, so a waiting result holds
//   the commit. The input reopens in the cycle after the commit.
// Reset (rst_ni low, async): all frames empty, ages and fault count zero,
//   frames_in_use back to 16. Frame pages are not cleared.
// ----------------------------------------------------------------------------
module lru_page_replacement_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream, tdata: [15:0] page_number; tlast: end_of_string
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  // result stream, tdata: [0] hit, [4:1] frame_index, [5] evicted_valid,
  //   [21:6] evicted_page, [37:22] fault_count, [39:38] zero; tlast: last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  // configuration port, register 0 (frames_in_use) at byte address 0
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] ADDR_FRAMES_IN_USE = 3'd0;
  localparam int         FR = lpr_pkg::FRAMES;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [lpr_pkg::CFG_W-1:0]     cfg_q;
  logic [lpr_pkg::K_W-1:0]       k_act;
  logic [lpr_pkg::PAGE_BITS-1:0] page_q;
  logic                          eos_q;
  logic [lpr_pkg::CNT_W-1:0]     fault_q, fault_d;
  lpr_pkg::carry_t               start_q, start_d;
  lpr_pkg::carry_t               fin_q;
  lpr_pkg::carry_t               chain [FR+1];
  lpr_pkg::cmd_t                 cmd;
  logic [FR-1:0]                 active;
  logic [FR:0]                   tok_vec;

  logic                          in_acc;
  logic                          out_free;
  logic                          commit;
  logic [lpr_pkg::IDX_W-1:0]     frame_sel;
  logic                          evict;

  logic                          m_tvalid_q;
  logic [39:0]                   out_data_q, out_data_d;
  logic                          out_last_q;

  // ---------------------------------------------------------------------------
  // Configuration: writes land on the access phase; zero counts as one frame,
  // anything above the frame count as all frames.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_FRAMES_IN_USE) ? {27'd0, cfg_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= lpr_pkg::CFG_W'(16);
    end else if (psel && penable && pwrite && pready &&
                 (paddr == ADDR_FRAMES_IN_USE)) begin
      cfg_q <= pwdata[lpr_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    logic [7:0] cfg_ext;
    cfg_ext = {3'd0, cfg_q};
    if (cfg_ext == 8'd0) begin
      k_act = lpr_pkg::K_W'(1);
    end else if (cfg_ext > 8'(FR)) begin
      k_act = lpr_pkg::K_W'(FR);
    end else begin
      k_act = cfg_ext[lpr_pkg::K_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Control: accept one reference, let its search record walk the chain,
  // commit once the result register is free.
  // ---------------------------------------------------------------------------
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_tvalid_q || m_axis_tready_i;
  assign commit          = (state_q == ST_DONE) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc)            state_d = ST_SCAN;
      ST_SCAN: if (chain[FR].tok)     state_d = ST_DONE;
      ST_DONE: if (out_free)          state_d = ST_IDLE;
      default:                        state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    start_d     = '0;
    start_d.tok = in_acc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      start_q <= '0;
    end else begin
      state_q <= state_d;
      start_q <= start_d;
    end
  end

  // hold the reference and the finished search record
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      page_q <= lpr_pkg::page_from_field(s_axis_tdata_i);
      eos_q  <= s_axis_tlast_i;
    end
    if (chain[FR].tok) begin
      fin_q <= chain[FR];
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain: one frame per cell, the record advances one cell per cycle.
  // ---------------------------------------------------------------------------
  assign chain[0] = start_q;

  for (genvar j = 0; j < FR; j++) begin : g_cell
    assign active[j] = (lpr_pkg::K_W'(j) < k_act);
    lpr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (lpr_pkg::IDX_W'(j)),
      .active_i(active[j]),
      .page_i  (page_q),
      .carry_i (chain[j]),
      .carry_o (chain[j+1]),
      .cmd_i   (cmd)
    );
  end

  for (genvar j = 0; j <= FR; j++) begin : g_tok
    assign tok_vec[j] = chain[j].tok;
  end

  // ---------------------------------------------------------------------------
  // Commit: pick the frame (hit, else first empty, else oldest), broadcast
  // the update, count misses, clear at string end, load the result register.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (fin_q.hit_found) begin
      frame_sel = fin_q.hit_idx;
    end else if (fin_q.empty_found) begin
      frame_sel = fin_q.empty_idx;
    end else begin
      frame_sel = fin_q.best_idx;
    end
    evict = !fin_q.hit_found && !fin_q.empty_found;
  end

  always_comb begin
    cmd.en      = commit;
    cmd.is_hit  = fin_q.hit_found;
    cmd.hit_age = fin_q.hit_age;
    cmd.frame   = frame_sel;
    cmd.page    = page_q;
    cmd.clear   = eos_q;
  end

  always_comb begin
    logic [lpr_pkg::CNT_W-1:0] cnt_new;
    logic [15:0]               ev_page;
    cnt_new = fault_q;
    if (!fin_q.hit_found && (fault_q != lpr_pkg::FAULT_MAX)) begin
      cnt_new = fault_q + 1'b1;
    end
    ev_page    = evict ? lpr_pkg::page_to_field(fin_q.best_page) : 16'd0;
    out_data_d = {2'b00, cnt_new, ev_page, evict,
                  lpr_pkg::idx_to_field(frame_sel), fin_q.hit_found};
    fault_d    = fault_q;
    if (commit) begin
      fault_d = eos_q ? '0 : cnt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q    <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      fault_q <= fault_d;
      if (commit) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_data_q <= out_data_d;
      out_last_q <= eos_q;
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_one_record : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one search record in the chain");

  a_tok_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[FR].tok |-> (state_q == ST_SCAN))
    else $error("search record left the chain outside the scan phase");

  a_frame_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.en |-> (lpr_pkg::K_W'(cmd.frame) < k_act))
    else $error("commit picked a frame outside the active set");

  a_hit_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.en && cmd.is_hit && !cmd.clear) |=> (fault_q == $past(fault_q)))
    else $error("fault count moved on a hit");

  a_commit_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> m_tvalid_q && (state_q == ST_IDLE))
    else $error("commit did not present a result");

endmodule

// ===== sim/lru_frame_checker.sv =====
// ----------------------------------------------------------------------------
// lru_frame_checker: result checker for the LRU page replacement block
// Watches the reference, result and APB channels, keeps its own copy of the
// frame table, recency ranks and fault count, predicts each result and
// compares it field by field against what the block returns.
// ----------------------------------------------------------------------------
module lru_frame_checker
  import lpr_pkg::*;
#(
  parameter logic [2:0] CFG_ADDR = 3'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] page_number
  input  logic        s_axis_tlast_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [39:0] m_axis_tdata_i,   // [0] hit, [4:1] frame, [5] evicted_valid,
                                        // [21:6] evicted_page, [37:22] faults
  input  logic        m_axis_tlast_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          hits_o,
  output int          evictions_o,
  output int          saturated_o
);

  typedef struct packed {
    logic              hit;
    logic [FIDX_W-1:0] frame;
    logic              ev_valid;
    logic [PFLD_W-1:0] ev_page;
    logic [CNT_W-1:0]  faults;
    logic              last;
  } lru_result_t;

  logic [PAGE_BITS-1:0] page_q [FRAMES];
  bit                   valid_q [FRAMES];
  logic [AGE_W-1:0]     age_q [FRAMES];
  logic [CNT_W-1:0]     faults_q;
  logic [CFG_W-1:0]     frames_cfg;

  lru_result_t expected_q [$];
  int errors, checked, hits, evictions, saturated;

  function automatic void clear_frames();
    for (int j = 0; j < FRAMES; j++) begin
      valid_q[j] = 1'b0;
      age_q[j]   = '0;
    end
    faults_q = '0;
  endfunction

  // make frame f the most recent; valid frames younger than limit age by one
  function automatic void promote_frame(int unsigned f, int unsigned limit);
    for (int j = 0; j < FRAMES; j++) begin
      if (j != f && valid_q[j] && age_q[j] < limit && age_q[j] < AGE_MAX)
        age_q[j] = age_q[j] + 1'b1;
    end
    age_q[f] = '0;
  endfunction

  function automatic lru_result_t replace_page(logic [PFLD_W-1:0] pg_field, logic eos);
    lru_result_t          r;
    logic [PAGE_BITS-1:0] pg;
    int unsigned          k, f, best;
    bit                   found, empty;
    pg    = pg_field[PAGE_BITS-1:0];
    k     = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAMES) ? FRAMES : frames_cfg);
    r     = '0;
    f     = 0;
    found = 1'b0;
    empty = 1'b0;
    for (int j = 0; j < k; j++) begin
      if (!found && valid_q[j] && page_q[j] == pg) begin
        f     = j;
        found = 1'b1;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      promote_frame(f, age_q[f]);
    end else begin
      for (int j = 0; j < k; j++) begin
        if (!empty && !valid_q[j]) begin
          f     = j;
          empty = 1'b1;
        end
      end
      if (!empty) begin
        // oldest active frame, lowest index on a tie
        best = 0;
        f    = 0;
        for (int j = 0; j < k; j++) begin
          if (age_q[j] > best) begin
            best = age_q[j];
            f    = j;
          end
        end
        r.ev_valid = 1'b1;
        r.ev_page  = page_q[f];
      end
      page_q[f]  = pg;
      valid_q[f] = 1'b1;
      promote_frame(f, FRAMES);
      if (faults_q != FAULT_MAX)
        faults_q = faults_q + 1'b1;
    end
    r.frame  = f[FIDX_W-1:0];
    r.faults = faults_q;
    r.last   = eos;
    if (eos)
      clear_frames();
    return r;
  endfunction

  function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    lru_result_t want;
    if (!rst_ni) begin
      for (int j = 0; j < FRAMES; j++)
        page_q[j] = '0;
      clear_frames();
      frames_cfg = CFG_W'(16);
      expected_q.delete();
    end else begin
      if (psel && penable && pready && paddr == CFG_ADDR) begin
        if (pwrite)
          frames_cfg = pwdata[CFG_W-1:0];
        else
          errors += field_differs("frames_in_use readback", {27'd0, frames_cfg}, prdata);
      end
      // retire results before queuing a new reference
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, got tdata 0x%0h tlast %0b", $time,
                   m_axis_tdata_i, m_axis_tlast_i);
          errors++;
        end else begin
          want = expected_q.pop_front();
          errors += field_differs("hit", want.hit, m_axis_tdata_i[0]);
          errors += field_differs("frame_index", want.frame, m_axis_tdata_i[4:1]);
          errors += field_differs("evicted_valid", want.ev_valid, m_axis_tdata_i[5]);
          errors += field_differs("evicted_page", want.ev_page, m_axis_tdata_i[21:6]);
          errors += field_differs("fault_count", want.faults, m_axis_tdata_i[37:22]);
          errors += field_differs("tdata padding", 0, m_axis_tdata_i[39:38]);
          errors += field_differs("last", want.last, m_axis_tlast_i);
          checked++;
          if (want.hit)                hits++;
          if (want.ev_valid)           evictions++;
          if (want.faults == FAULT_MAX) saturated++;
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        expected_q.push_back(replace_page(s_axis_tdata_i, s_axis_tlast_i));
    end
    fail_count_o <= errors;
    pending_o    <= expected_q.size();
    checked_o    <= checked;
    hits_o       <= hits;
    evictions_o  <= evictions;
    saturated_o  <= saturated;
  end

endmodule

// ===== sim/lru_page_replacement_top_test.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement_top_test: stimulus and verdict for the LRU frame block
// Drives page references with random gaps, a randomly stalling result sink
// and APB writes of frames_in_use between phases. A directed part walks the
// corner cases, then random phases run page pools under varied frame counts.
// ----------------------------------------------------------------------------
module lru_page_replacement_top_test;
  import lpr_pkg::*;

  localparam logic [2:0] FRAMES_IN_USE_ADDR = 3'd0;
  localparam int RANDOM_ITEMS   = 2000;
  localparam int DRAIN_CYCLES   = FRAMES + 3 + 16;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_valid  = 1'b0;
  logic [15:0] s_data   = '0;
  logic        s_last   = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready  = 1'b0;
  logic [39:0] m_data;
  logic        m_last;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        no_idle  = 1'b0;

  int fail_count, pending, checked, hits, evictions, saturated;
  int settings_used = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  lru_page_replacement_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  lru_frame_checker #(
    .CFG_ADDR (FRAMES_IN_USE_ADDR)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tlast_i  (m_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked),
    .hits_o          (hits),
    .evictions_o     (evictions),
    .saturated_o     (saturated)
  );

  // Result sink: drop tready at random about 7 percent of the time, unless the
  // current phase runs without idling.
  always @(posedge clk_i) begin
    if (no_idle) begin
      m_ready <= 1'b1;
    end else begin
      m_ready <= ($urandom_range(99) >= 7);
    end
  end

  // Offer one page reference and hold it until the block takes it. The
  // valid stays high on return so that back-to-back transactions keep it up.
  task automatic send_ref(input logic [15:0] pg, input logic eos);
    while (!no_idle && $urandom_range(99) < 7) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= pg;
    s_last  <= eos;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  // Drop valid and hold off until every predicted result has been returned.
  // The first edge lets the checker count the last accepted transaction.
  task automatic wait_drained();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Write frames_in_use through APB with random upper data bits, then read
  // it back so the checker can compare the stored value.
  task automatic set_frames_in_use(input logic [CFG_W-1:0] v);
    logic [31:0] word;
    word         = $urandom();
    word[CFG_W-1:0] = v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FRAMES_IN_USE_ADDR;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    int unsigned          sent, n, pool_size, phase;
    logic [15:0]          pool_base, pg;
    logic                 eos;
    logic [CFG_W-1:0]     cfg;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full frame set straight out of reset: extreme pages, a hit, string end.
    send_ref(16'h0000, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'h5555, 1'b0);
    send_ref(16'hAAAA, 1'b1);

    // Two frames: eviction of the oldest page, a hit, then another eviction.
    wait_drained();
    set_frames_in_use(CFG_W'(2));
    send_ref(16'h0001, 1'b0);
    send_ref(16'h0002, 1'b0);
    send_ref(16'h0003, 1'b0);
    send_ref(16'h0002, 1'b0);
    send_ref(16'h0004, 1'b1);

    // A zero register acts as a single frame.
    wait_drained();
    set_frames_in_use(CFG_W'(0));
    send_ref(16'h0007, 1'b0);
    send_ref(16'h0007, 1'b0);
    send_ref(16'h0008, 1'b1);

    // An oversized register acts as the full frame set.
    wait_drained();
    set_frames_in_use(CFG_W'(31));
    send_ref(16'h0009, 1'b0);
    send_ref(16'h0009, 1'b1);

    // Shrink the active set over a live string: the page in an inactive frame
    // misses and lands again in an active one, leaving a duplicate copy that
    // the lowest-numbered frame wins once the set grows back.
    wait_drained();
    set_frames_in_use(CFG_W'(4));
    send_ref(16'h0010, 1'b0);
    send_ref(16'h0011, 1'b0);
    send_ref(16'h0012, 1'b0);
    send_ref(16'h0013, 1'b0);
    wait_drained();
    set_frames_in_use(CFG_W'(2));
    send_ref(16'h0012, 1'b0);
    wait_drained();
    set_frames_in_use(CFG_W'(4));
    send_ref(16'h0012, 1'b1);

    // Random phases: each picks a frame count and a pool of nearby pages so
    // that hits, evictions and aging all happen; a tenth of the references
    // are noise from the whole page range. One phase runs with no idling.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      case ($urandom_range(6))
        0:       cfg = CFG_W'(0);
        1:       cfg = CFG_W'(1);
        2:       cfg = CFG_W'(16);
        3:       cfg = CFG_W'(31);
        4:       cfg = CFG_W'($urandom_range(17, 30));
        default: cfg = CFG_W'($urandom_range(2, 15));
      endcase
      set_frames_in_use(cfg);
      no_idle   <= (phase == 6);
      pool_size = $urandom_range(1, 20);
      pool_base = 16'($urandom());
      n         = (phase == 6) ? 300 : $urandom_range(20, 120);
      repeat (n) begin
        if ($urandom_range(9) == 0) begin
          pg = 16'($urandom());
        end else begin
          pg = pool_base + 16'($urandom_range(pool_size - 1));
        end
        eos = ($urandom_range(39) == 0);
        send_ref(pg, eos);
        sent++;
      end
      phase++;
    end

    // Drain, then give the pipeline time to show any stray result.
    wait_drained();
    no_idle <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d references over %0d frame-count settings,", checked, settings_used);
    $display("with %0d hits, %0d evictions and %0d results at the fault count ceiling.",
             hits, evictions, saturated);
    if (pending != 0)
      $display("%0t: %0d predicted results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #1_000_000;
    $display("Timeout with %0d results still pending", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lpr_pkg.sv
hdl/lpr_cell.sv
hdl/lru_page_replacement_top.sv
sim/lru_frame_checker.sv
sim/lru_page_replacement_top_test.sv
